@@ rtl/bl2rgb_pkg.sv @@
// Shared types and constants for the BMP line to RGB24 converter.
// No dependencies; imported by the front, back and top-level modules.
package bl2rgb_pkg;

    localparam int LPW = 12;
    localparam int QDEPTH = 4;
    localparam int QAW = $clog2(QDEPTH);
    localparam int QCW = $clog2(QDEPTH + 1);

    localparam logic CMD_DATA = 1'b0;
    localparam logic CMD_PULL = 1'b1;

    localparam logic [1:0] CFG_LINE_PIXELS = 2'd0;
    localparam logic [1:0] CFG_PAD_BYTES   = 2'd1;
    localparam logic [1:0] CFG_MIRROR      = 2'd2;

    localparam logic [LPW-1:0] RST_LINE_PIXELS = 12'd640;
    localparam logic [1:0]     RST_PAD_BYTES   = 2'd0;
    localparam logic           RST_MIRROR      = 1'b1;

    typedef struct packed {
        logic       cmd;
        logic [7:0] data_byte;
    } t_in_word;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       line_end;
    } t_out_word;

    typedef struct packed {
        logic vld;
        logic last;
    } t_rd_ctl;

endpackage

@@ rtl/bmp_line_to_rgb24.sv @@
// Top level of the BMP 24-bit line to RGB24 byte stream converter.
// Depends on bl2rgb_pkg, bl2rgb_front and bl2rgb_back.
//
// Input side is a queue write port: a word {cmd, data_byte} is taken at a
// clock edge with push high and full low. cmd DATA stores a pixel or pad
// byte; cmd PULL only drains one output byte. Results come out of a queue
// read port: while empty is low the oldest {out_byte, line_end} word is
// shown and it is taken at an edge with pop high.
// Throughput is one input word per cycle while full is low. A word that
// yields a result shows it on the output ports once it has passed the
// line store read, registered at its accept edge, and the result queue,
// written at the next edge.
// A completed line is emitted B/R swapped, mirrored when enabled, while
// the next line fills the other bank of the line store.
// Reset clears positions and the line-ready flag and loads line_pixels
// 640, pad_bytes 0, mirror 1; the line store is not cleared.
// When pop stays low the 4-word result queue fills and full rises,
// one slot being held for the read in flight; config writes on the
// i_cfg_* port take effect at the next edge and are expected while idle.
module bmp_line_to_rgb24 import bl2rgb_pkg::*; #(
    parameter int MAX_PIXELS = 2048
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cfg_we,
    input  logic [1:0]     i_cfg_idx,
    input  logic [LPW-1:0] i_cfg_data,
    input  logic           push,
    output logic           full,
    input  t_in_word       i_in_word,
    output logic           empty,
    input  logic           pop,
    output t_out_word      o_out_word
);

    localparam int AW = $clog2(6 * MAX_PIXELS);
    localparam int BANK = 3 * MAX_PIXELS;

    logic          acc;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [7:0]    wr_data;
    t_rd_ctl       rd_ctl;
    logic [AW-1:0] rd_addr;

    assign acc = push && !full;

    bl2rgb_front #(
        .MAX_PIXELS(MAX_PIXELS),
        .AW        (AW)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg_we  (i_cfg_we),
        .i_cfg_idx (i_cfg_idx),
        .i_cfg_data(i_cfg_data),
        .i_acc     (acc),
        .i_word    (i_in_word),
        .o_wr_en   (wr_en),
        .o_wr_addr (wr_addr),
        .o_wr_data (wr_data),
        .o_rd_ctl  (rd_ctl),
        .o_rd_addr (rd_addr)
    );

    bl2rgb_back #(
        .MAX_PIXELS(MAX_PIXELS),
        .AW        (AW)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_wr_en  (wr_en),
        .i_wr_addr(wr_addr),
        .i_wr_data(wr_data),
        .i_rd_ctl (rd_ctl),
        .i_rd_addr(rd_addr),
        .i_pop    (pop),
        .o_full   (full),
        .o_empty  (empty),
        .o_word   (o_out_word)
    );

    a_bank_split: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (wr_en && rd_ctl.vld) |-> ((wr_addr >= AW'(BANK)) != (rd_addr >= AW'(BANK))))
        else $error("line store read and write hit the same bank");

    a_no_idle_access: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !acc |-> (!wr_en && !rd_ctl.vld))
        else $error("line store access without an accepted word");

    a_addr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rd_ctl.vld |-> (rd_addr < AW'(2 * BANK)))
        else $error("line store read address out of range");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> (empty && !full))
        else $error("result queue not empty after reset");

endmodule

@@ rtl/bl2rgb_front.sv @@
// Front end: config registers, fill/drain position tracking, line store address generation.
// Depends on bl2rgb_pkg.
module bl2rgb_front import bl2rgb_pkg::*; #(
    parameter int MAX_PIXELS = 2048,
    parameter int AW = $clog2(6 * MAX_PIXELS)
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cfg_we,
    input  logic [1:0]     i_cfg_idx,
    input  logic [LPW-1:0] i_cfg_data,
    input  logic           i_acc,
    input  t_in_word       i_word,
    output logic           o_wr_en,
    output logic [AW-1:0]  o_wr_addr,
    output logic [7:0]     o_wr_data,
    output t_rd_ctl        o_rd_ctl,
    output logic [AW-1:0]  o_rd_addr
);

    localparam int PW = $clog2(MAX_PIXELS + 1);
    localparam int CW = (PW > LPW) ? PW : LPW;
    localparam int SW = $clog2(3 * MAX_PIXELS + 4);
    localparam int BANK = 3 * MAX_PIXELS;

    logic [LPW-1:0] r_line_pixels;
    logic [1:0]     r_pad;
    logic           r_mirror;

    logic [SW-1:0]  r_wpos, n_wpos;
    logic           r_wbank, n_wbank;
    logic [PW-1:0]  r_rpix, n_rpix;
    logic [1:0]     r_rch, n_rch;
    logic           r_ready, n_ready;

    logic [CW-1:0]  lp_ext;
    logic [PW-1:0]  npix;
    logic [PW-1:0]  spix;
    logic [SW-1:0]  useful;
    logic [SW-1:0]  wrap_len;
    logic [SW-1:0]  wpos_inc;
    logic [1:0]     chan;
    logic [1:0]     schan;
    logic           rp_over;
    logic           rd_live;
    logic           last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_pixels <= RST_LINE_PIXELS;
            r_pad         <= RST_PAD_BYTES;
            r_mirror      <= RST_MIRROR;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_LINE_PIXELS: r_line_pixels <= i_cfg_data;
                CFG_PAD_BYTES:   r_pad         <= i_cfg_data[1:0];
                CFG_MIRROR:      r_mirror      <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        lp_ext = CW'(r_line_pixels);
        if (lp_ext == '0) begin
            npix = PW'(1);
        end else if (lp_ext > CW'(MAX_PIXELS)) begin
            npix = PW'(MAX_PIXELS);
        end else begin
            npix = PW'(lp_ext);
        end
    end

    assign useful   = SW'({npix, 1'b0}) + SW'(npix);
    assign wrap_len = useful + SW'(r_pad);
    assign wpos_inc = r_wpos + SW'(1);

    assign rp_over = r_rpix >= npix;
    assign rd_live = r_ready && !rp_over;
    assign chan    = (r_rch > 2'd2) ? 2'd2 : r_rch;
    assign schan   = 2'd2 - chan;
    assign spix    = r_mirror ? (npix - PW'(1) - r_rpix) : r_rpix;
    assign last    = (r_rpix == npix - PW'(1)) && (chan == 2'd2);

    assign o_rd_addr = (r_wbank ? AW'(0) : AW'(BANK)) + AW'({spix, 1'b0}) + AW'(spix)
                     + AW'(schan);
    assign o_rd_ctl.vld  = i_acc && rd_live;
    assign o_rd_ctl.last = last;

    assign o_wr_en   = i_acc && (i_word.cmd == CMD_DATA) && (r_wpos < useful);
    assign o_wr_addr = (r_wbank ? AW'(BANK) : AW'(0)) + AW'(r_wpos);
    assign o_wr_data = i_word.data_byte;

    always_comb begin
        n_wpos  = r_wpos;
        n_wbank = r_wbank;
        n_rpix  = r_rpix;
        n_rch   = r_rch;
        n_ready = r_ready;
        if (i_acc) begin
            if (r_ready && rp_over) begin
                n_ready = 1'b0;
                n_rpix  = '0;
                n_rch   = '0;
            end
            if (rd_live) begin
                if (chan == 2'd2) begin
                    n_rch  = '0;
                    n_rpix = r_rpix + PW'(1);
                end else begin
                    n_rch = chan + 2'd1;
                end
                if (last) begin
                    n_ready = 1'b0;
                    n_rpix  = '0;
                    n_rch   = '0;
                end
            end
            if (i_word.cmd == CMD_DATA) begin
                n_wpos = wpos_inc;
                if (wpos_inc >= wrap_len) begin
                    n_wpos  = '0;
                    n_wbank = ~r_wbank;
                    n_ready = 1'b1;
                    n_rpix  = '0;
                    n_rch   = '0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wpos  <= '0;
            r_wbank <= 1'b0;
            r_rpix  <= '0;
            r_rch   <= '0;
            r_ready <= 1'b0;
        end else begin
            r_wpos  <= n_wpos;
            r_wbank <= n_wbank;
            r_rpix  <= n_rpix;
            r_rch   <= n_rch;
            r_ready <= n_ready;
        end
    end

endmodule

@@ rtl/bl2rgb_back.sv @@
// Back end: two-bank line store, registered read, and the result word queue.
// Depends on bl2rgb_pkg.
module bl2rgb_back import bl2rgb_pkg::*; #(
    parameter int MAX_PIXELS = 2048,
    parameter int AW = $clog2(6 * MAX_PIXELS)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  logic [7:0]    i_wr_data,
    input  t_rd_ctl       i_rd_ctl,
    input  logic [AW-1:0] i_rd_addr,
    input  logic          i_pop,
    output logic          o_full,
    output logic          o_empty,
    output t_out_word     o_word
);

    localparam int DEPTH = 6 * MAX_PIXELS;

    logic [7:0]     r_mem [DEPTH];
    logic [7:0]     r_rd_data;
    logic           r_rd_vld;
    logic           r_rd_last;

    t_out_word      r_q [QDEPTH];
    logic [QAW-1:0] r_wp, r_rp;
    logic [QCW-1:0] r_cnt, n_cnt;
    logic [QCW:0]   used;
    logic           q_pop;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_ctl.vld) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_ctl.vld) begin
            r_rd_last <= i_rd_ctl.last;
        end
        if (!i_rst_n) begin
            r_rd_vld <= 1'b0;
        end else begin
            r_rd_vld <= i_rd_ctl.vld;
        end
    end

    assign used    = (QCW + 1)'(r_cnt) + (QCW + 1)'(r_rd_vld);
    assign o_full  = used >= (QCW + 1)'(QDEPTH);
    assign o_empty = r_cnt == '0;
    assign q_pop   = i_pop && !o_empty;
    assign o_word  = r_q[r_rp];

    always_comb begin
        n_cnt = r_cnt;
        if (r_rd_vld && !q_pop) begin
            n_cnt = r_cnt + QCW'(1);
        end else if (!r_rd_vld && q_pop) begin
            n_cnt = r_cnt - QCW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_rd_vld) begin
            r_q[r_wp] <= '{out_byte: r_rd_data, line_end: r_rd_last};
        end
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (r_rd_vld) begin
                r_wp <= r_wp + QAW'(1);
            end
            if (q_pop) begin
                r_rp <= r_rp + QAW'(1);
            end
            r_cnt <= n_cnt;
        end
    end

endmodule

@@ tb/tb_bmp_line_to_rgb24.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for bmp_line_to_rgb24: directed table, then random line streams.
// Depends on bl2rgb_pkg and the bmp_line_to_rgb24 RTL; results checked by an in-bench predictor.
module tb_bmp_line_to_rgb24;
    import bl2rgb_pkg::*;

    localparam int MAXPIX = 2048;
    localparam int BANK = MAXPIX * 3;
    localparam int SETTLE_CYCLES = 8;
    localparam int HOLD_CYCLES = 400;
    localparam int WDOG_LIMIT = 3000;
    localparam int DIR_ROWS = 34;

    typedef enum logic [1:0] {ROW_CFG, ROW_ITEM} t_row_kind;
    typedef enum logic [1:0] {CHK_PRED, CHK_NONE, CHK_WORD} t_chk;

    typedef struct packed {
        t_row_kind  kind;
        logic [1:0] idx;
        logic [11:0] val;
        logic       cmd;
        logic [7:0] dat;
        t_chk       chk;
        logic [7:0] xbyte;
        logic       xend;
    } t_stim_row;

    localparam t_stim_row DIR_TAB [DIR_ROWS] = '{
        '{ROW_ITEM, CFG_LINE_PIXELS, 12'd0, CMD_PULL, 8'h00, CHK_NONE, 8'h00, 1'b0},
        '{ROW_CFG,  CFG_LINE_PIXELS, 12'd1, CMD_DATA, 8'h00, CHK_NONE, 8'h00, 1'b0},
        '{ROW_CFG,  CFG_PAD_BYTES,   12'd3, CMD_DATA, 8'h00, CHK_NONE, 8'h00, 1'b0},
        '{ROW_ITEM, CFG_LINE_PIXELS, 12'd0, CMD_DATA, 8'h00, CHK_NONE, 8'h00, 1'b0},
        '{ROW_ITEM, CFG_LINE_PIXELS, 12'd0, CMD_DATA, 8'h7f, CHK_NONE, 8'h00, 1'b0},
        '{ROW_ITEM, CFG_LINE_PIXELS, 12'd0, CMD_DATA, 8'hff, CHK_NONE, 8'h00, 1'b0},
        '{ROW_ITEM, CFG_LINE_PIXELS, 12'd0, CMD_DATA, 8'haa, CHK_NONE, 8'h00, 1'b0},
        '{ROW_ITEM, CFG_LINE_PIXELS, 12'd0, CMD_DATA, 8'h55, CHK_NONE, 8'h00, 1'b0},
        '{ROW_ITEM, CFG_LINE_PIXELS, 12'd0, CMD_DATA, 8'h3c, CHK_NONE, 8'h00, 1'b0},
        '{ROW_ITEM, CFG_LINE_PIXELS, 12'd0, CMD_PULL, 8'h00, CHK_WORD, 8'hff, 1'b0},
        '{ROW_ITEM, CFG_LINE_PIXELS, 12'd0, CMD_PULL, 8'h00, CHK_WORD, 8'h7f, 1'b0},
        '{ROW_ITEM, CFG_LINE_PIXELS, 12'd0, CMD_PULL, 8'h00, CHK_WORD, 8'h00, 1'b1},
        '{ROW_ITEM, CFG_LINE_PIXELS, 12'd0, CMD_PULL, 8'h00, CHK_NONE, 8'h00, 1'b0},
        '{ROW_CFG,  CFG_PAD_BYTES,   12'd0, CMD_DATA, 8'h00, CHK_NONE, 8'h00, 1'b0},
        '{ROW_CFG,  CFG_LINE_PIXELS, 12'd2, CMD_DATA, 8'h00, CHK_NONE, 8'h00, 1'b0},
        '{ROW_ITEM, CFG_LINE_PIXELS, 12'd0, CMD_DATA, 8'h01, CHK_NONE, 8'h00, 1'b0},
        '{ROW_ITEM, CFG_LINE_PIXELS, 12'd0, CMD_DATA, 8'h02, CHK_NONE, 8'h00, 1'b0},
        '{ROW_ITEM, CFG_LINE_PIXELS, 12'd0, CMD_DATA, 8'h03, CHK_NONE, 8'h00, 1'b0},
        '{ROW_ITEM, CFG_LINE_PIXELS, 12'd0, CMD_DATA, 8'h04, CHK_NONE, 8'h00, 1'b0},
        '{ROW_ITEM, CFG_LINE_PIXELS, 12'd0, CMD_DATA, 8'h05, CHK_NONE, 8'h00, 1'b0},
        '{ROW_ITEM, CFG_LINE_PIXELS, 12'd0, CMD_DATA, 8'h06, CHK_NONE, 8'h00, 1'b0},
        '{ROW_ITEM, CFG_LINE_PIXELS, 12'd0, CMD_DATA, 8'h80, CHK_WORD, 8'h06, 1'b0},
        '{ROW_ITEM, CFG_LINE_PIXELS, 12'd0, CMD_DATA, 8'h81, CHK_WORD, 8'h05, 1'b0},
        '{ROW_ITEM, CFG_LINE_PIXELS, 12'd0, CMD_DATA, 8'h82, CHK_WORD, 8'h04, 1'b0},
        '{ROW_ITEM, CFG_LINE_PIXELS, 12'd0, CMD_DATA, 8'h83, CHK_WORD, 8'h03, 1'b0},
        '{ROW_ITEM, CFG_LINE_PIXELS, 12'd0, CMD_DATA, 8'h84, CHK_WORD, 8'h02, 1'b0},
        '{ROW_ITEM, CFG_LINE_PIXELS, 12'd0, CMD_DATA, 8'h85, CHK_WORD, 8'h01, 1'b1},
        '{ROW_CFG,  CFG_MIRROR,      12'd0, CMD_DATA, 8'h00, CHK_NONE, 8'h00, 1'b0},
        '{ROW_ITEM, CFG_LINE_PIXELS, 12'd0, CMD_PULL, 8'h00, CHK_WORD, 8'h82, 1'b0},
        '{ROW_ITEM, CFG_LINE_PIXELS, 12'd0, CMD_PULL, 8'h00, CHK_WORD, 8'h81, 1'b0},
        '{ROW_ITEM, CFG_LINE_PIXELS, 12'd0, CMD_PULL, 8'h00, CHK_WORD, 8'h80, 1'b0},
        '{ROW_ITEM, CFG_LINE_PIXELS, 12'd0, CMD_PULL, 8'h00, CHK_WORD, 8'h85, 1'b0},
        // shrink to one pixel while the read sits past it: line ends silently
        '{ROW_CFG,  CFG_LINE_PIXELS, 12'd0, CMD_DATA, 8'h00, CHK_NONE, 8'h00, 1'b0},
        '{ROW_ITEM, CFG_LINE_PIXELS, 12'd0, CMD_PULL, 8'h00, CHK_NONE, 8'h00, 1'b0}
    };

    logic           i_clk;
    logic           i_rst_n;
    logic           i_cfg_we;
    logic [1:0]     i_cfg_idx;
    logic [LPW-1:0] i_cfg_data;
    logic           push;
    logic           full;
    t_in_word       i_in_word;
    logic           empty;
    logic           pop;
    t_out_word      o_out_word;

    // predictor state
    logic [7:0]  line_mem [2*BANK];
    logic [11:0] lp_reg;
    logic [1:0]  pad_reg;
    logic        mir_reg;
    int          wr_pos;
    bit          wr_bank;
    int          rd_pix;
    int          rd_ch;
    bit          rdy;

    t_out_word rgb_expected [$];
    int        err_count = 0;
    int        stall_cycles = 0;
    int        hold_reqs = 0;
    bit        tx_no_idle = 0;
    bit        rx_no_idle = 0;

    bmp_line_to_rgb24 #(.MAX_PIXELS(MAXPIX)) DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .push       (push),
        .full       (full),
        .i_in_word  (i_in_word),
        .empty      (empty),
        .pop        (pop),
        .o_out_word (o_out_word)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic int eff_len(logic [11:0] v);
        if (v == 0) return 1;
        if (v > MAXPIX) return MAXPIX;
        return int'(v);
    endfunction

    function automatic t_stim_row rand_row(int pull_pct);
        t_stim_row r;
        r = '0;
        r.kind = ROW_ITEM;
        r.chk = CHK_PRED;
        r.cmd = ($urandom_range(0, 99) < pull_pct) ? CMD_PULL : CMD_DATA;
        r.dat = 8'($urandom);
        return r;
    endfunction

    task automatic rgb_predict(input t_in_word w, output bit got, output t_out_word res);
        int  npix, useful, ch, spix, addr;
        bit  last_b;
        npix = eff_len(lp_reg);
        useful = npix * 3;
        got = 1'b0;
        res = '0;
        if (rdy && rd_pix >= npix) begin
            rdy = 1'b0;
            rd_pix = 0;
            rd_ch = 0;
        end
        if (rdy) begin
            ch = (rd_ch > 2) ? 2 : rd_ch;
            spix = mir_reg ? (npix - 1 - rd_pix) : rd_pix;
            addr = (wr_bank ? 0 : BANK) + spix * 3 + (2 - ch);
            last_b = (rd_pix == npix - 1) && (ch == 2);
            res.out_byte = line_mem[addr];
            res.line_end = last_b;
            got = 1'b1;
            if (ch == 2) begin
                rd_ch = 0;
                rd_pix++;
            end else begin
                rd_ch = ch + 1;
            end
            if (last_b) begin
                rdy = 1'b0;
                rd_pix = 0;
                rd_ch = 0;
            end
        end
        if (w.cmd == CMD_DATA) begin
            if (wr_pos < useful) line_mem[(wr_bank ? BANK : 0) + wr_pos] = w.data_byte;
            wr_pos++;
            if (wr_pos >= useful + int'(pad_reg)) begin
                wr_pos = 0;
                wr_bank = ~wr_bank;
                rdy = 1'b1;
                rd_pix = 0;
                rd_ch = 0;
            end
        end
    endtask

    task automatic offer_word(input t_stim_row r);
        int        gap;
        bit        got;
        t_out_word pw;
        t_in_word  w;
        w.cmd = r.cmd;
        w.data_byte = r.dat;
        gap = tx_no_idle ? 0 : pick_gap();
        @(negedge i_clk);
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        push <= 1'b1;
        i_in_word <= w;
        do @(posedge i_clk); while (full);
        rgb_predict(w, got, pw);
        case (r.chk)
            CHK_WORD: rgb_expected.push_back(t_out_word'{out_byte: r.xbyte, line_end: r.xend});
            CHK_PRED: if (got) rgb_expected.push_back(pw);
            default: ;
        endcase
    endtask

    task automatic idle_sender();
        @(negedge i_clk);
        push <= 1'b0;
    endtask

    // growing the line past a ready one would read stale entries: drain it first
    task automatic apply_setting(input logic [1:0] idx, input logic [11:0] val);
        if (idx == CFG_LINE_PIXELS && eff_len(val) > eff_len(lp_reg)) begin
            while (rdy) offer_word(rand_row(100));
        end
        idle_sender();
        while (rgb_expected.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_LINE_PIXELS: lp_reg = val;
            CFG_PAD_BYTES:   pad_reg = val[1:0];
            CFG_MIRROR:      mir_reg = val[0];
            default: ;
        endcase
    endtask

    initial begin : pop_drive
        int stall_left;
        int holds_seen;
        stall_left = 0;
        holds_seen = 0;
        pop = 1'b0;
        wait (i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_reqs != holds_seen) begin
                holds_seen = hold_reqs;
                pop <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
            end else if (stall_left > 0) begin
                pop <= 1'b0;
                stall_left--;
            end else begin
                pop <= 1'b1;
                if (!rx_no_idle && $urandom_range(0, 3) == 0) stall_left = pick_gap();
            end
        end
    end

    always @(posedge i_clk) begin : rgb_check
        t_out_word want;
        if (i_rst_n && pop && !empty) begin
            if (rgb_expected.size() == 0) begin
                err_count++;
                $display("%0t: unexpected word, expected none, got byte %h end %b",
                         $time, o_out_word.out_byte, o_out_word.line_end);
            end else begin
                want = rgb_expected.pop_front();
                if (o_out_word.out_byte !== want.out_byte) begin
                    err_count++;
                    $display("%0t: out_byte expected %h got %h",
                             $time, want.out_byte, o_out_word.out_byte);
                end
                if (o_out_word.line_end !== want.line_end) begin
                    err_count++;
                    $display("%0t: line_end expected %b got %b",
                             $time, want.line_end, o_out_word.line_end);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((push && !full) || (pop && !empty) || i_cfg_we) stall_cycles <= 0;
        else stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= WDOG_LIMIT) begin
            $display("%0t: no progress for %0d cycles", $time, WDOG_LIMIT);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin : stim
        int ph;
        int pull_pct;
        int k;
        logic [11:0] lp_pick;
        i_rst_n = 1'b0;
        push = 1'b0;
        i_in_word = '0;
        i_cfg_we = 1'b0;
        i_cfg_idx = CFG_LINE_PIXELS;
        i_cfg_data = '0;
        lp_reg = RST_LINE_PIXELS;
        pad_reg = RST_PAD_BYTES;
        mir_reg = RST_MIRROR;
        wr_pos = 0;
        wr_bank = 1'b0;
        rd_pix = 0;
        rd_ch = 0;
        rdy = 1'b0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (k = 0; k < DIR_ROWS; k++) begin
            if (DIR_TAB[k].kind == ROW_CFG) apply_setting(DIR_TAB[k].idx, DIR_TAB[k].val);
            else offer_word(DIR_TAB[k]);
        end

        for (ph = 0; ph < 12; ph++) begin
            tx_no_idle = (ph % 4 == 1) || (ph == 5);
            rx_no_idle = (ph % 4 == 2);
            pull_pct = (ph % 3 == 0) ? 40 : 12;
            case ($urandom_range(0, 9))
                0:       lp_pick = 12'd0;
                1:       lp_pick = 12'd1;
                default: lp_pick = 12'($urandom_range(2, 12));
            endcase
            apply_setting(CFG_LINE_PIXELS, lp_pick);
            apply_setting(CFG_PAD_BYTES, 12'($urandom_range(0, 3)));
            apply_setting(CFG_MIRROR, 12'($urandom_range(0, 1)));
            if (ph == 5) hold_reqs++;
            repeat (145) offer_word(rand_row(pull_pct));
        end

        idle_sender();
        while (rgb_expected.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (err_count == 0) $display("SCOREBOARD CLEAN");
        else $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
